@@ design/bsrt_pkg.sv @@
// Shared types, widths and constants of the bounded simplex ratio test.
`default_nettype none
package bsrt_pkg;

  localparam int unsigned DATA_W     = 32;
  localparam int unsigned NUM_W      = DATA_W + 1;
  localparam int unsigned IDX_W      = 10;
  localparam int unsigned TOL_W      = 16;
  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned FRAC_W     = 16;
  localparam int unsigned CNT_W      = 6;

  localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE    = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ENTERING_NEG = 8'd1;

  localparam logic [TOL_W-1:0] TOL_RESET = 16'd1;

  localparam logic signed [DATA_W-1:0] SAT_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [DATA_W-1:0] SAT_MIN = 32'sh8000_0000;

  typedef struct packed {
    logic signed [DATA_W-1:0] direction_component;
    logic signed [DATA_W-1:0] current_value;
    logic signed [DATA_W-1:0] lower_bound;
    logic signed [DATA_W-1:0] upper_bound;
    logic [IDX_W-1:0]         variable_index;
    logic                     last_row;
  } row_t;

  typedef struct packed {
    logic [IDX_W-1:0]         leaving_index;
    logic signed [DATA_W-1:0] step_length;
    logic                     unbounded;
  } result_t;

  typedef struct packed {
    logic                    start;
    logic signed [NUM_W-1:0] num;
    logic [DATA_W-1:0]       den;
  } div_req_t;

  typedef struct packed {
    logic                     done;
    logic signed [DATA_W-1:0] quotient;
  } div_rsp_t;

endpackage
`default_nettype wire

@@ design/bsrt_if.sv @@
// Handshake channels for rows, results and configuration writes.
`default_nettype none
interface bsrt_row_if;
  logic          valid;
  logic          ready;
  bsrt_pkg::row_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface bsrt_res_if;
  logic             valid;
  logic             ready;
  bsrt_pkg::result_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface bsrt_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [bsrt_pkg::CFG_IDX_W-1:0]      index;
  logic [bsrt_pkg::CFG_DATA_W-1:0]     wdata;
  modport source (output valid, output index, output wdata, input ready);
  modport sink (input valid, input index, input wdata, output ready);
endinterface
`default_nettype wire

@@ design/bsrt_div.sv @@
// Radix-2 restoring divider, one quotient bit per cycle, saturating Q16.16 result.
`default_nettype none
module bsrt_div (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire bsrt_pkg::div_req_t req_i,
  output bsrt_pkg::div_rsp_t      rsp_o
);

  localparam logic [bsrt_pkg::CNT_W-1:0] CNT_SETUP = 6'd33;
  localparam logic [bsrt_pkg::CNT_W-1:0] CNT_LAST  = 6'd0;

  logic                           busy_q, busy_d;
  logic [bsrt_pkg::CNT_W-1:0]     cnt_q, cnt_d;
  logic                           done_q, done_d;
  logic                           neg_q;
  logic                           ovf_q;
  logic [bsrt_pkg::DATA_W-1:0]    mag_q;
  logic [bsrt_pkg::DATA_W-1:0]    den_q;
  logic [bsrt_pkg::DATA_W-1:0]    rem_q;
  logic [bsrt_pkg::DATA_W-1:0]    dvd_q;
  logic [bsrt_pkg::DATA_W-1:0]    quo_q;
  logic signed [bsrt_pkg::DATA_W-1:0] res_q;

  logic [bsrt_pkg::NUM_W-1:0]     num_abs;
  logic [bsrt_pkg::NUM_W-1:0]     trial;
  logic                           big;
  logic signed [bsrt_pkg::DATA_W-1:0] sat;

  assign num_abs = req_i.num[bsrt_pkg::NUM_W-1] ? (~req_i.num + 1'b1) : req_i.num;
  assign trial   = {1'b0, rem_q[bsrt_pkg::DATA_W-2:0], dvd_q[bsrt_pkg::DATA_W-1]}
                 - {1'b0, den_q};
  assign big     = ovf_q | quo_q[bsrt_pkg::DATA_W-1];

  always_comb begin
    if (neg_q) begin
      sat = big ? bsrt_pkg::SAT_MIN : $signed(~quo_q + 1'b1);
    end else begin
      sat = big ? bsrt_pkg::SAT_MAX : $signed(quo_q);
    end
  end

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = CNT_SETUP;
    end else if (busy_q) begin
      if (cnt_q == CNT_LAST) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      neg_q <= req_i.num[bsrt_pkg::NUM_W-1];
      mag_q <= num_abs[bsrt_pkg::DATA_W-1:0];
      den_q <= req_i.den;
    end else if (busy_q) begin
      if (cnt_q == CNT_SETUP) begin
        ovf_q <= {{bsrt_pkg::FRAC_W{1'b0}}, mag_q[bsrt_pkg::DATA_W-1:bsrt_pkg::FRAC_W]}
                 >= den_q;
        rem_q <= {{bsrt_pkg::FRAC_W{1'b0}}, mag_q[bsrt_pkg::DATA_W-1:bsrt_pkg::FRAC_W]};
        dvd_q <= {mag_q[bsrt_pkg::FRAC_W-1:0], {bsrt_pkg::FRAC_W{1'b0}}};
        quo_q <= '0;
      end else if (cnt_q == CNT_LAST) begin
        res_q <= sat;
      end else begin
        dvd_q <= {dvd_q[bsrt_pkg::DATA_W-2:0], 1'b0};
        if (!trial[bsrt_pkg::NUM_W-1]) begin
          rem_q <= trial[bsrt_pkg::DATA_W-1:0];
          quo_q <= {quo_q[bsrt_pkg::DATA_W-2:0], 1'b1};
        end else begin
          rem_q <= {rem_q[bsrt_pkg::DATA_W-2:0], dvd_q[bsrt_pkg::DATA_W-1]};
          quo_q <= {quo_q[bsrt_pkg::DATA_W-2:0], 1'b0};
        end
      end
    end
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = res_q;

endmodule
`default_nettype wire

@@ design/bounded_simplex_ratio_test_top.sv @@
// Top level of the bounded simplex ratio test: row classification and running minimum.
// A limiting row passes from acceptance through the states PREP, DIV (radix-2 divider) and UPD
// before the next acceptance; a row that imposes no limit goes from PREP straight to UPD.
// Throughput is one row at a time. A result leaves through an output register
// in the cycle after the last row's update.
// Reset (rst_ni low, asynchronous) restores tolerance 1, entering increasing, empty pass.
`default_nettype none
module bounded_simplex_ratio_test_top (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  bsrt_row_if.sink   row_i,
  bsrt_res_if.source res_o,
  bsrt_cfg_if.sink   cfg_i
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_PREP = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;
  localparam logic [1:0] ST_UPD  = 2'd3;

  logic [1:0] state_q, state_d;
  logic       start_q, start_d;

  logic [bsrt_pkg::TOL_W-1:0] tol_q;
  logic                       ent_neg_q;

  logic signed [bsrt_pkg::DATA_W-1:0] best_step_q, best_step_d;
  logic                               best_inf_q, best_inf_d;
  logic [bsrt_pkg::IDX_W-1:0]         best_idx_q, best_idx_d;

  logic                res_valid_q, res_valid_d;
  logic                res_load;
  bsrt_pkg::result_t   res_data_q, res_data_d;

  bsrt_pkg::row_t                     row_q;
  logic                               limited_q;
  logic signed [bsrt_pkg::NUM_W-1:0]  num_q;
  logic [bsrt_pkg::DATA_W-1:0]        den_q;

  logic signed [bsrt_pkg::NUM_W-1:0]  d_ext;
  logic signed [bsrt_pkg::NUM_W-1:0]  s_val;
  logic signed [bsrt_pkg::NUM_W-1:0]  tol_ext;
  logic                               gt_tol;
  logic                               lt_tol;
  logic signed [bsrt_pkg::NUM_W-1:0]  num_up;
  logic signed [bsrt_pkg::NUM_W-1:0]  num_dn;
  logic [bsrt_pkg::DATA_W-1:0]        den_abs;

  logic signed [bsrt_pkg::DATA_W-1:0] step;
  logic                               take_new;
  logic                               take_tie;
  logic signed [bsrt_pkg::DATA_W-1:0] nb_step;
  logic                               nb_inf;
  logic [bsrt_pkg::IDX_W-1:0]         nb_idx;
  logic                               stall;

  bsrt_pkg::div_req_t div_req;
  bsrt_pkg::div_rsp_t div_rsp;

  assign row_i.ready = (state_q == ST_IDLE);
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q     <= bsrt_pkg::TOL_RESET;
      ent_neg_q <= 1'b0;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        bsrt_pkg::CFG_TOLERANCE:    tol_q     <= cfg_i.wdata[bsrt_pkg::TOL_W-1:0];
        bsrt_pkg::CFG_ENTERING_NEG: ent_neg_q <= cfg_i.wdata[0];
        default: ;
      endcase
    end
  end

  assign d_ext   = {row_q.direction_component[bsrt_pkg::DATA_W-1], row_q.direction_component};
  assign s_val   = ent_neg_q ? d_ext : -d_ext;
  assign tol_ext = $signed({{(bsrt_pkg::NUM_W-bsrt_pkg::TOL_W){1'b0}}, tol_q});
  assign gt_tol  = s_val > tol_ext;
  assign lt_tol  = s_val < -tol_ext;
  assign num_up  = {row_q.upper_bound[bsrt_pkg::DATA_W-1], row_q.upper_bound}
                 - {row_q.current_value[bsrt_pkg::DATA_W-1], row_q.current_value};
  assign num_dn  = {row_q.current_value[bsrt_pkg::DATA_W-1], row_q.current_value}
                 - {row_q.lower_bound[bsrt_pkg::DATA_W-1], row_q.lower_bound};
  assign den_abs = row_q.direction_component[bsrt_pkg::DATA_W-1]
                 ? (~row_q.direction_component + 1'b1) : row_q.direction_component;

  assign div_req.start = start_q;
  assign div_req.num   = num_q;
  assign div_req.den   = den_q;

  bsrt_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign step     = div_rsp.quotient;
  assign take_new = limited_q && (best_inf_q || (step < best_step_q));
  assign take_tie = limited_q && !best_inf_q && (step == best_step_q)
                 && (row_q.variable_index < best_idx_q);
  assign nb_step  = take_new ? step : best_step_q;
  assign nb_inf   = take_new ? 1'b0 : best_inf_q;
  assign nb_idx   = (take_new || take_tie) ? row_q.variable_index : best_idx_q;
  assign stall    = row_q.last_row && res_valid_q && !res_o.ready;

  always_comb begin
    res_data_d.leaving_index = nb_inf ? '0 : nb_idx;
    res_data_d.step_length   = nb_inf ? '0 : nb_step;
    res_data_d.unbounded     = nb_inf;
  end

  always_comb begin
    state_d     = state_q;
    start_d     = 1'b0;
    best_step_d = best_step_q;
    best_inf_d  = best_inf_q;
    best_idx_d  = best_idx_q;
    res_valid_d = res_valid_q && !res_o.ready;
    res_load    = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (row_i.valid) begin
          state_d = ST_PREP;
        end
      end
      ST_PREP: begin
        if (gt_tol || lt_tol) begin
          start_d = 1'b1;
          state_d = ST_DIV;
        end else begin
          state_d = ST_UPD;
        end
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          state_d = ST_UPD;
        end
      end
      ST_UPD: begin
        if (!stall) begin
          state_d = ST_IDLE;
          if (row_q.last_row) begin
            res_load    = 1'b1;
            res_valid_d = 1'b1;
            best_step_d = '0;
            best_inf_d  = 1'b1;
            best_idx_d  = '0;
          end else begin
            best_step_d = nb_step;
            best_inf_d  = nb_inf;
            best_idx_d  = nb_idx;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      start_q     <= 1'b0;
      best_step_q <= '0;
      best_inf_q  <= 1'b1;
      best_idx_q  <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      start_q     <= start_d;
      best_step_q <= best_step_d;
      best_inf_q  <= best_inf_d;
      best_idx_q  <= best_idx_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (row_i.valid && row_i.ready) begin
      row_q <= row_i.data;
    end
    if (state_q == ST_PREP) begin
      limited_q <= gt_tol || lt_tol;
      num_q     <= gt_tol ? num_up : num_dn;
      den_q     <= den_abs;
    end
    if (res_load) begin
      res_data_q <= res_data_d;
    end
  end

  assign res_o.valid = res_valid_q;
  assign res_o.data  = res_data_q;

`ifndef ASSERT_OFF
  a_done_in_div : assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> (state_q == ST_DIV))
    else $error("divider finished outside the divide state");

  a_accept_prep : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (row_i.valid && row_i.ready) |=> (state_q == ST_PREP))
    else $error("accepted request not followed by preparation");

  a_last_emits : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_UPD && row_q.last_row && !stall) |=> (res_valid_q && best_inf_q))
    else $error("last row did not emit a result and clear the pass");

  a_unbounded_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && res_data_q.unbounded) |->
      (res_data_q.step_length == '0 && res_data_q.leaving_index == '0))
    else $error("unbounded result carries a non-zero step or index");
`endif

endmodule
`default_nettype wire
